/* design/ocmt_pkg.sv */
// ocmt_pkg: shared types and constants for the ordered channel match table
// no dependencies; imported by every module of the block
package ocmt_pkg;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_FULL   = 2'd0,
    CMD_CAPROV = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_DONE
  } state_t;

  // field widths
  localparam int SRV_W  = 16;
  localparam int CA_W   = 16;
  localparam int PROV_W = 24;
  localparam int PID_W  = 13;
  localparam int CHAN_W = 24;
  localparam int CNT_OUT_W = 7;

  // change count saturates here
  localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 7'd127;

  // one stored channel record
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [PID_W-1:0]  ecm_pid;
    logic [PROV_W-1:0] provider;
    logic [CA_W-1:0]   ca_system;
    logic [SRV_W-1:0]  service;
  } rec_t;

  // one accepted request
  typedef struct packed {
    cmd_t cmd;
    rec_t rec;
  } query_t;

  // compare results for one stored record against the request
  typedef struct packed {
    logic full_hit;
    logic ca_hit;
    logic chan_eq;
  } match_t;

  // one result item
  typedef struct packed {
    logic                 hit;
    rec_t                 rec;
    logic [CNT_OUT_W-1:0] change_count;
    logic                 add_dropped;
  } result_t;

endpackage

/* design/ordered_channel_match_table_top.sv */
// ordered_channel_match_table_top: stream wrapper and output register
// depends on ocmt_pkg, ocmt_rec_mem, ocmt_match and ocmt_ctrl
//
//  channel | direction | tdata                         | tuser
//  s_      | in        | service, ca, provider, pid,   | cmd
//          |           | channel                       |
//  m_      | out       | hit record, change count,     | hit
//          |           | add dropped                   |
//
// a transfer reads the record store once per stored entry, through a single
// shared compare unit, and then passes through drain, end-of-scan, append and
// hand-off; a lookup stops after its first hit, and the next transfer is taken
// in the cycle after the result is registered.
// rst clears the sequencer, the fill count and the output valid; the
// record store is not cleared. a stalled result holds in the output
// register while the next transfer is accepted and processed.
module ordered_channel_match_table_top import ocmt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // service_id[15:0], ca_system_id[31:16], provider_id[55:32],
  // ecm_pid[68:56], channel_id[92:69], zero pad[95:93]
  input  logic [95:0]  s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_service_id[15:0], hit_ca_system_id[31:16], hit_provider_id[55:32],
  // hit_ecm_pid[68:56], hit_channel_id[92:69], change_count[99:93],
  // add_dropped[100], zero pad[103:101]
  output logic [103:0] m_tdata,
  // hit[0]
  output logic         m_tuser
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  query_t           query_in;
  query_t           query;
  match_t           match;
  result_t          result;
  logic             idle;
  logic             done;
  logic             out_free;
  logic             start;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  rec_t             mem_rdata;

  // unpack the input transfer
  assign query_in.cmd           = cmd_t'(s_tuser);
  assign query_in.rec.service   = s_tdata[15:0];
  assign query_in.rec.ca_system = s_tdata[31:16];
  assign query_in.rec.provider  = s_tdata[55:32];
  assign query_in.rec.ecm_pid   = s_tdata[68:56];
  assign query_in.rec.channel   = s_tdata[92:69];

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign out_free = !m_tvalid || m_tready;

  ocmt_rec_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ocmt_match u_match (
    .rec    (mem_rdata),
    .query  (query),
    .result (match)
  );

  ocmt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .query_in  (query_in),
    .idle      (idle),
    .done      (done),
    .result    (result),
    .out_free  (out_free),
    .query     (query),
    .match     (match),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_tuser <= result.hit;
      m_tdata <= {3'b000, result.add_dropped, result.change_count,
                  result.rec.channel, result.rec.ecm_pid, result.rec.provider,
                  result.rec.ca_system, result.rec.service};
    end
  end

endmodule

/* design/ocmt_rec_mem.sv */
// ocmt_rec_mem: record store, one write port and one registered read port
// depends on ocmt_pkg for the record type
module ocmt_rec_mem import ocmt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  rec_t             wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ocmt_match.sv */
// ocmt_match: shared compare unit, one stored record against the request
// depends on ocmt_pkg for record, request and match types
module ocmt_match import ocmt_pkg::*; (
  input  rec_t   rec,
  input  query_t query,
  output match_t result
);

  logic prov_ok;

  // provider of zero in the request matches any stored provider
  assign prov_ok = (query.rec.provider == '0) || (rec.provider == query.rec.provider);

  assign result.ca_hit   = (rec.ca_system == query.rec.ca_system) && prov_ok;
  assign result.full_hit = result.ca_hit && (rec.service == query.rec.service) &&
                           (rec.ecm_pid == query.rec.ecm_pid);
  assign result.chan_eq  = (rec.channel == query.rec.channel);

endmodule

/* design/ocmt_ctrl.sv */
// ocmt_ctrl: sequencer that scans, compacts and appends table records
// depends on ocmt_pkg; drives ocmt_rec_mem and reads ocmt_match
module ocmt_ctrl import ocmt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  query_t           query_in,
  output logic             idle,
  output logic             done,
  output result_t          result,
  input  logic             out_free,
  output query_t           query,
  input  match_t           match,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output rec_t             mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  rec_t             mem_rdata
);

  localparam int SUM_W = (CNT_W + 1 > CNT_OUT_W) ? CNT_W + 1 : CNT_OUT_W;

  state_t           state, state_next;
  query_t           query_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] keep, keep_next;
  logic [CNT_W-1:0] removed, removed_next;
  logic [CNT_W-1:0] pidx, pidx_next;
  logic             pv, pv_next;
  logic             stopped, stopped_next;
  logic             hit_f, hit_f_next;
  rec_t             hit_rec, hit_rec_next;
  result_t          result_next;

  logic             is_lookup;
  logic             is_add;
  logic             sel_match;
  logic             issue;
  logic             keep_entry;
  logic [SUM_W-1:0] sum;

  assign is_lookup = (query.cmd == CMD_FULL) || (query.cmd == CMD_CAPROV);
  assign is_add    = (query.cmd == CMD_ADD);
  assign sel_match = (query.cmd == CMD_CAPROV) ? match.ca_hit : match.full_hit;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      pv      <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      pv      <= pv_next;
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    query   <= query_next;
    rd_ptr  <= rd_ptr_next;
    keep    <= keep_next;
    removed <= removed_next;
    pidx    <= pidx_next;
    stopped <= stopped_next;
    hit_f   <= hit_f_next;
    hit_rec <= hit_rec_next;
    result  <= result_next;
  end

  // next state, scan datapath and memory control
  always_comb begin
    state_next   = state;
    query_next   = query;
    fill_next    = fill;
    rd_ptr_next  = rd_ptr;
    keep_next    = keep;
    removed_next = removed;
    pidx_next    = pidx;
    pv_next      = 1'b0;
    stopped_next = stopped;
    hit_f_next   = hit_f;
    hit_rec_next = hit_rec;
    result_next  = result;
    idle         = 1'b0;
    done         = 1'b0;
    issue        = 1'b0;
    keep_entry   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = keep[IDX_W-1:0];
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr[IDX_W-1:0];
    sum          = SUM_W'(removed);

    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          query_next   = query_in;
          rd_ptr_next  = '0;
          keep_next    = '0;
          removed_next = '0;
          stopped_next = 1'b0;
          hit_f_next   = 1'b0;
          state_next   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read one entry per cycle, stop early once a lookup has hit
        issue       = (rd_ptr != fill) && !hit_f;
        mem_re      = issue;
        pv_next     = issue;
        pidx_next   = rd_ptr;
        if (issue) begin
          rd_ptr_next = rd_ptr + 1'b1;
        end

        // process the entry read in the previous cycle
        if (pv) begin
          if (is_lookup) begin
            if (!hit_f && sel_match) begin
              hit_f_next   = 1'b1;
              hit_rec_next = mem_rdata;
            end
          end else begin
            if (!stopped && match.full_hit) begin
              if (is_add && match.chan_eq) begin
                stopped_next = 1'b1;
                keep_entry   = 1'b1;
              end else begin
                removed_next = removed + 1'b1;
              end
            end else begin
              keep_entry = 1'b1;
            end
            // compact: surviving entry moves down to the keep slot
            if (keep_entry) begin
              mem_we    = (keep != pidx);
              keep_next = keep + 1'b1;
            end
          end
        end

        if (!pv && ((rd_ptr == fill) || hit_f)) begin
          state_next = ST_APPEND;
        end
      end

      ST_APPEND: begin
        result_next.hit          = is_lookup && hit_f;
        result_next.rec          = (is_lookup && hit_f) ? hit_rec : '0;
        result_next.change_count = '0;
        result_next.add_dropped  = 1'b0;
        if (!is_lookup) begin
          fill_next = keep;
          if (is_add && !stopped) begin
            if (keep < CNT_W'(DEPTH)) begin
              // append the new record at the end of the table
              mem_we    = 1'b1;
              mem_wdata = query.rec;
              fill_next = keep + 1'b1;
              sum       = SUM_W'(removed) + SUM_W'(1);
            end else begin
              result_next.add_dropped = 1'b1;
            end
          end
          if (is_add && stopped) begin
            result_next.change_count = '0;
          end else if (sum > SUM_W'(COUNT_MAX)) begin
            result_next.change_count = COUNT_MAX;
          end else begin
            result_next.change_count = sum[CNT_OUT_W-1:0];
          end
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        done = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* tb/ordered_channel_match_table_top_test.sv */
`timescale 1ns / 1ps
// self-checking bench for ordered_channel_match_table_top: directed and random requests,
// checked against an in-bench mirror of the channel table. needs ocmt_pkg and the block rtl
module ordered_channel_match_table_top_test;
  import ocmt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 4000;

  // mirror of the channel table: predicts each reply and checks it in order
  class channel_table_mirror;
    rec_t    records[$];
    result_t pending_replies[$];
    int      depth;
    int      errors;
    int      checked;
    int      lookups;
    int      lookup_hits;
    int      add_stops;
    int      add_drops;

    function new(int table_depth);
      depth = table_depth;
      errors = 0;
      checked = 0;
      lookups = 0;
      lookup_hits = 0;
      add_stops = 0;
      add_drops = 0;
    endfunction

    function int stored();
      return records.size();
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // query provider 0 matches any stored provider
    function bit provider_ok(rec_t r, rec_t q);
      return q.provider == '0 || r.provider == q.provider;
    endfunction

    function bit full_match(rec_t r, rec_t q);
      return r.service == q.service && r.ca_system == q.ca_system &&
             r.ecm_pid == q.ecm_pid && provider_ok(r, q);
    endfunction

    // update the table for one accepted request and queue the reply it owes
    function void note_request(cmd_t op, rec_t q);
      result_t reply;
      rec_t    kept[$];
      int      removed;
      int      count;
      bit      stopped;
      bit      m;
      reply = '0;
      removed = 0;
      stopped = 1'b0;
      if (op == CMD_FULL || op == CMD_CAPROV) begin
        lookups++;
        for (int i = 0; i < records.size(); i++) begin
          if (op == CMD_CAPROV)
            m = records[i].ca_system == q.ca_system && provider_ok(records[i], q);
          else
            m = full_match(records[i], q);
          if (m) begin
            reply.hit = 1'b1;
            reply.rec = records[i];
            lookup_hits++;
            break;
          end
        end
      end else begin
        // scan in order, drop matches, stop an add on an equal channel id
        for (int i = 0; i < records.size(); i++) begin
          if (!stopped && full_match(records[i], q)) begin
            if (op == CMD_ADD && records[i].channel == q.channel) begin
              stopped = 1'b1;
            end else begin
              removed++;
              continue;
            end
          end
          kept.push_back(records[i]);
        end
        records = kept;
        count = removed;
        if (op == CMD_ADD) begin
          if (stopped) begin
            count = 0;
            add_stops++;
          end else if (records.size() < depth) begin
            records.push_back(q);
            count = removed + 1;
          end else begin
            reply.add_dropped = 1'b1;
            add_drops++;
          end
        end
        if (count > COUNT_MAX) count = int'(COUNT_MAX);
        reply.change_count = count[CNT_OUT_W-1:0];
      end
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one output transfer with the oldest queued reply
    function void check_result(logic hit, logic [103:0] data);
      result_t want;
      rec_t    got;
      got = data[92:0];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, hit %b tdata %h", $time, hit, data);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      compare_field("hit", 32'(want.hit), 32'(hit));
      compare_field("hit_service_id", 32'(want.rec.service), 32'(got.service));
      compare_field("hit_ca_system_id", 32'(want.rec.ca_system), 32'(got.ca_system));
      compare_field("hit_provider_id", 32'(want.rec.provider), 32'(got.provider));
      compare_field("hit_ecm_pid", 32'(want.rec.ecm_pid), 32'(got.ecm_pid));
      compare_field("hit_channel_id", 32'(want.rec.channel), 32'(got.channel));
      compare_field("change_count", 32'(want.change_count), 32'(data[99:93]));
      compare_field("add_dropped", 32'(want.add_dropped), 32'(data[100]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = CMD_FULL;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;

  channel_table_mirror mirror;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int requests = 0;

  // key pools so that random requests collide with stored records
  logic [15:0] srv_pool [4] = '{16'h0001, 16'h0002, 16'hFFFF, 16'h8000};
  logic [15:0] ca_pool [3] = '{16'h0100, 16'h0500, 16'h0000};
  logic [23:0] prov_pool [4] = '{24'h000000, 24'h000011, 24'h000022, 24'hFFFFFF};
  logic [12:0] pid_pool [3] = '{13'h0020, 13'h1FFF, 13'h0000};
  logic [23:0] chan_pool [3] = '{24'h000001, 24'h000002, 24'h000003};

  ordered_channel_match_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_result(m_tuser, m_tdata);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("ordered_channel_match_table_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rec_t make_rec(logic [15:0] srv, logic [15:0] ca, logic [23:0] prov,
                                    logic [12:0] pid, logic [23:0] chan);
    rec_t r;
    r.service = srv;
    r.ca_system = ca;
    r.provider = prov;
    r.ecm_pid = pid;
    r.channel = chan;
    return r;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_item(cmd_t op, rec_t q);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, q};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.note_request(op, q);
    requests++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // lookups and remove on an empty table
    send_item(CMD_FULL, make_rec(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 13'h1FFF, 24'hFFFFFF));
    send_item(CMD_CAPROV, make_rec(16'h0, 16'h0, 24'h0, 13'h0, 24'h0));
    send_item(CMD_REMOVE, make_rec(16'h0001, 16'h0100, 24'h000011, 13'h0020, 24'h0));
    // plain adds, all-ones and all-zero records
    send_item(CMD_ADD, make_rec(16'h0001, 16'h0100, 24'h000011, 13'h0020, 24'h00000A));
    send_item(CMD_ADD, make_rec(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 13'h1FFF, 24'hFFFFFF));
    send_item(CMD_ADD, make_rec(16'h0, 16'h0, 24'h0, 13'h0, 24'h0));
    // exact, wildcard and wrong provider lookups
    send_item(CMD_FULL, make_rec(16'h0001, 16'h0100, 24'h000011, 13'h0020, 24'h0));
    send_item(CMD_FULL, make_rec(16'h0001, 16'h0100, 24'h000000, 13'h0020, 24'h0));
    send_item(CMD_FULL, make_rec(16'h0001, 16'h0100, 24'h000012, 13'h0020, 24'h0));
    send_item(CMD_CAPROV, make_rec(16'h1234, 16'h0100, 24'h000000, 13'h0555, 24'h0));
    send_item(CMD_CAPROV, make_rec(16'h0, 16'hFFFF, 24'hFFFFFF, 13'h0, 24'h0));
    send_item(CMD_CAPROV, make_rec(16'h0, 16'h0100, 24'h000099, 13'h0, 24'h0));
    // replace on a new channel id, then repeat with the same one
    send_item(CMD_ADD, make_rec(16'h0001, 16'h0100, 24'h000011, 13'h0020, 24'h00000B));
    send_item(CMD_ADD, make_rec(16'h0001, 16'h0100, 24'h000011, 13'h0020, 24'h00000B));
    // add that removes one record and then stops on an equal channel id
    send_item(CMD_ADD, make_rec(16'h0777, 16'h0500, 24'h000011, 13'h0100, 24'h000001));
    send_item(CMD_ADD, make_rec(16'h0777, 16'h0500, 24'h000022, 13'h0100, 24'h000002));
    send_item(CMD_ADD, make_rec(16'h0777, 16'h0500, 24'h000000, 13'h0100, 24'h000002));
    send_item(CMD_FULL, make_rec(16'h0777, 16'h0500, 24'h000000, 13'h0100, 24'h0));
    // remove with wildcard provider takes several records
    send_item(CMD_ADD, make_rec(16'h0777, 16'h0500, 24'h000033, 13'h0100, 24'h000003));
    send_item(CMD_ADD, make_rec(16'h0777, 16'h0500, 24'h000044, 13'h0100, 24'h000004));
    send_item(CMD_REMOVE, make_rec(16'h0777, 16'h0500, 24'h000000, 13'h0100, 24'h0));
    send_item(CMD_REMOVE, make_rec(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 13'h1FFF, 24'hFFFFFF));
  endtask

  // mostly pool-based requests, some fully random noise
  task automatic send_random();
    rec_t q;
    cmd_t op;
    int   roll;
    roll = $urandom_range(99);
    if (roll < 85) begin
      q = make_rec(srv_pool[2'($urandom_range(3))], ca_pool[2'($urandom_range(2))],
                   prov_pool[2'($urandom_range(3))], pid_pool[2'($urandom_range(2))],
                   chan_pool[2'($urandom_range(2))]);
      roll = $urandom_range(99);
      if (roll < 40) op = CMD_ADD;
      else if (roll < 60) op = CMD_FULL;
      else if (roll < 75) op = CMD_CAPROV;
      else op = CMD_REMOVE;
    end else begin
      q = make_rec(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                   24'($urandom_range(24'hFFFFFF)), 13'($urandom_range(13'h1FFF)),
                   24'($urandom_range(24'hFFFFFF)));
      op = cmd_t'(2'($urandom_range(3)));
    end
    send_item(op, q);
  endtask

  task automatic run_phase(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random();
    wait_drain();
  endtask

  function automatic rec_t fill_key(int slot);
    return make_rec(16'h4000 + slot[15:0], 16'h0A0A, 24'h000000, 13'h0ABC,
                    24'h800000 + slot[23:0]);
  endfunction

  // fill the table, hit the full case, then remove the fill records again
  task automatic fill_then_drain();
    rec_t q;
    int   slots;
    slots = 0;
    idle_pct = 11;
    stall_pct = 11;
    while (mirror.stored() < TABLE_DEPTH) begin
      q = fill_key(slots);
      q.provider = 24'($urandom_range(1, 24'hFFFFFF));
      send_item(CMD_ADD, q);
      slots++;
    end
    for (int k = 0; k < 3; k++) send_item(CMD_ADD, fill_key(200 + k));
    send_item(CMD_ADD, fill_key(0));
    q = fill_key(1);
    q.channel = 24'h123456;
    send_item(CMD_ADD, q);
    for (int k = 0; k < slots; k++) send_item(CMD_REMOVE, fill_key(k));
    wait_drain();
  endtask

  initial begin
    mirror = new(TABLE_DEPTH);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_drain();
    run_phase(170, 0, 0);
    fill_then_drain();
    // long receiver hold-off while the sender keeps offering
    hold_request = 400;
    run_phase(170, 0, 75);
    run_phase(170, 75, 0);
    run_phase(170, 11, 11);

    stall_pct = 0;
    repeat (TABLE_DEPTH + 16) @(posedge clk);

    $display("%0d requests sent: %0d lookups (%0d hits), %0d adds stopped on a known channel,",
             requests, mirror.lookups, mirror.lookup_hits, mirror.add_stops);
    $display("%0d adds dropped on a full table; %0d results checked, %0d mismatches",
             mirror.add_drops, mirror.checked, mirror.errors);
    if (mirror.errors == 0 && mirror.outstanding() == 0) begin
      $display("ordered_channel_match_table_top_test: done, clean");
    end else begin
      $display("ordered_channel_match_table_top_test: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/ocmt_pkg.sv
design/ocmt_rec_mem.sv
design/ocmt_match.sv
design/ocmt_ctrl.sv
design/ordered_channel_match_table_top.sv
tb/ordered_channel_match_table_top_test.sv
